// ----- hdl/tcw_pkg.sv -----
`default_nettype none
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // payload widths of the two channels
  localparam int CHAR_W    = 8;
  localparam int INDEX_W   = 11;
  localparam int COL_OUT_W = 7;
  localparam int ROW_OUT_W = 5;
  localparam int CELL_W    = 7;

  localparam int QUEUE_DEPTH = 4;
  localparam int TAB_STEP    = 4;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [CHAR_W-1:0] CHAR_FIRST = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_LAST  = 8'h7E;
  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;

  localparam logic [CELL_W-1:0] SPACE_CELL = 7'h20;

  typedef enum logic [2:0] {
    OP_PUT,
    OP_BS,
    OP_TAB,
    OP_NL,
    OP_CR,
    OP_NOP,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CELL_W-1:0] code;
    logic [INDEX_W-1:0] index;
  } req_t;

endpackage
`default_nettype wire

// ----- hdl/tcw_if.sv -----
`default_nettype none
interface tcw_req_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [tcw_pkg::CHAR_W-1:0]  char_code;
  logic [tcw_pkg::INDEX_W-1:0] cell_index;

  modport source (output valid, command, char_code, cell_index, input ready);
  modport sink (input valid, command, char_code, cell_index, output ready);
endinterface

interface tcw_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [tcw_pkg::COL_OUT_W-1:0] cursor_column;
  logic [tcw_pkg::ROW_OUT_W-1:0] cursor_row;
  logic                          scrolled;
  logic [tcw_pkg::CELL_W-1:0]    read_char;

  modport source (output valid, cursor_column, cursor_row, scrolled, read_char,
                  input ready);
  modport sink (input valid, cursor_column, cursor_row, scrolled, read_char,
                output ready);
endinterface
`default_nettype wire

// ----- hdl/tcw_front.sv -----
`default_nettype none
module tcw_front (
  input  wire logic          clk,
  input  wire logic          rst,
  tcw_req_if.sink            request,
  input  wire logic          init_done,
  output tcw_pkg::req_t      fq_data,
  output logic               fq_valid,
  input  wire logic          fq_ready
);

  logic          stage_valid;
  tcw_pkg::req_t stage;
  tcw_pkg::req_t decoded;
  logic          take;

  always_comb begin
    decoded.code  = request.char_code[tcw_pkg::CELL_W-1:0];
    decoded.index = request.cell_index;
    if (request.command == tcw_pkg::CMD_READ) begin
      decoded.op = tcw_pkg::OP_READ;
    end else if (request.char_code >= tcw_pkg::CHAR_FIRST &&
                 request.char_code <= tcw_pkg::CHAR_LAST) begin
      decoded.op = tcw_pkg::OP_PUT;
    end else begin
      unique case (request.char_code)
        tcw_pkg::CHAR_BS:  decoded.op = tcw_pkg::OP_BS;
        tcw_pkg::CHAR_TAB: decoded.op = tcw_pkg::OP_TAB;
        tcw_pkg::CHAR_NL:  decoded.op = tcw_pkg::OP_NL;
        tcw_pkg::CHAR_CR:  decoded.op = tcw_pkg::OP_CR;
        default:           decoded.op = tcw_pkg::OP_NOP;
      endcase
    end
  end

  // no requests while the grid is being cleared after reset
  assign request.ready = init_done && (!stage_valid || fq_ready);
  assign take          = request.valid && request.ready;
  assign fq_valid      = stage_valid;
  assign fq_data       = stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (take) begin
      stage_valid <= 1'b1;
    end else if (fq_ready) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stage <= decoded;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/tcw_fifo.sv -----
`default_nettype none
module tcw_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire tcw_pkg::req_t push_data,
  input  wire logic          push_valid,
  output logic               push_ready,
  output tcw_pkg::req_t      pop_data,
  output logic               pop_valid,
  input  wire logic          pop_ready
);

  localparam int DEPTH = tcw_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CNTW  = $clog2(DEPTH + 1);

  tcw_pkg::req_t   slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;
  logic            push;
  logic            pop;

  assign push_ready = count != CNTW'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/tcw_back.sv -----
`default_nettype none
module tcw_back #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire tcw_pkg::req_t rq_data,
  input  wire logic          rq_valid,
  output logic               rq_ready,
  output logic               init_done,
  tcw_rsp_if.source          result
);

  localparam int CW      = $clog2(COLUMNS);
  localparam int RW      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int XW      = CW + 3;
  localparam int AW      = RW + CW;
  localparam int DEPTH   = ROWS * (2 ** CW);
  localparam int IW      = tcw_pkg::INDEX_W;
  localparam int SHIFT   = IW + CW;
  localparam int RECIP   = (2 ** SHIFT + COLUMNS - 1) / COLUMNS;
  localparam int RECIP_W = IW + 2;
  localparam int PROD_W  = IW + RECIP_W;
  localparam int QC_W    = IW + 9;
  localparam int CNT_W   = IW + 8;
  localparam int CELLS   = ROWS * COLUMNS;
  localparam int OCW     = tcw_pkg::COL_OUT_W;
  localparam int ORW     = tcw_pkg::ROW_OUT_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_MUL,
    S_RD_ADR,
    S_RD_MEM,
    S_RD_OUT
  } state_t;

  state_t state;

  // cursor and circular row mapping
  logic [CW-1:0] col;
  logic [RW-1:0] line;
  logic [RW-1:0] top;
  logic [RW-1:0] cur_prow;

  logic [CW-1:0] clr_col;
  logic [RW-1:0] clr_row;
  logic          clr_all;

  logic [IW-1:0]     rd_idx;
  logic [PROD_W-1:0] prod;
  logic [AW-1:0]     raddr;
  logic              rd_ok;

  logic [tcw_pkg::CELL_W-1:0] grid [DEPTH];
  logic [tcw_pkg::CELL_W-1:0] mem_q;
  logic                       we;
  logic [AW-1:0]              waddr;
  logic [tcw_pkg::CELL_W-1:0] wdata;

  logic                       out_valid;
  logic                       out_load;
  logic [OCW-1:0]             o_col;
  logic [ORW-1:0]             o_row;
  logic                       o_scr;
  logic [tcw_pkg::CELL_W-1:0] o_char;

  logic          slot_free;
  logic          pop;
  logic [XW-1:0] nc;
  logic          nl;
  logic          wrap;
  logic          line_step;
  logic          scroll;
  logic [CW-1:0] col_next;
  logic [RW-1:0] line_next;
  logic          clr_done;

  logic [IW-1:0]   quot;
  logic [QC_W-1:0] qc;
  logic [IW-1:0]   rem;
  logic [RW:0]     psum;
  logic [RW-1:0]   prow;
  logic            in_range;

  function automatic logic [RW-1:0] row_inc(input logic [RW-1:0] r);
    return (r == RW'(ROWS - 1)) ? '0 : r + 1'b1;
  endfunction

  assign slot_free = !out_valid || result.ready;
  assign pop       = (state == S_IDLE) && rq_valid && slot_free;
  assign rq_ready  = pop;
  assign init_done = !((state == S_CLEAR) && clr_all);
  assign out_load  = (pop && rq_data.op != tcw_pkg::OP_READ) ||
                     ((state == S_RD_OUT) && slot_free);

  assign result.valid         = out_valid;
  assign result.cursor_column = o_col;
  assign result.cursor_row    = o_row;
  assign result.scrolled      = o_scr;
  assign result.read_char     = o_char;

  // cursor update for put and control requests
  always_comb begin
    nl = 1'b0;
    unique case (rq_data.op)
      tcw_pkg::OP_PUT: nc = XW'(col) + 1'b1;
      tcw_pkg::OP_BS:  nc = (col == '0) ? XW'(col) : XW'(col) - 1'b1;
      tcw_pkg::OP_TAB: nc = (XW'(col) + XW'(tcw_pkg::TAB_STEP)) &
                            ~XW'(tcw_pkg::TAB_STEP - 1);
      tcw_pkg::OP_NL: begin
        nc = '0;
        nl = 1'b1;
      end
      tcw_pkg::OP_CR:  nc = '0;
      default:         nc = XW'(col);
    endcase
    wrap      = nc >= XW'(COLUMNS);
    line_step = nl || wrap;
    col_next  = wrap ? '0 : CW'(nc);
    scroll    = line_step && (line == RW'(ROWS - 1));
    line_next = (line_step && !scroll) ? line + 1'b1 : line;
  end

  // cell index split into row and column by reciprocal multiply
  always_comb begin
    quot     = IW'(prod >> SHIFT);
    qc       = QC_W'(quot) * QC_W'(COLUMNS);
    rem      = rd_idx - IW'(qc);
    in_range = CNT_W'(rd_idx) < CNT_W'(CELLS);
    psum     = {1'b0, quot[RW-1:0]} + {1'b0, top};
    prow     = (psum >= (RW + 1)'(ROWS)) ? RW'(psum - (RW + 1)'(ROWS)) : RW'(psum);
  end

  assign clr_done = (clr_col == CW'(COLUMNS - 1)) &&
                    (!clr_all || clr_row == RW'(ROWS - 1));

  always_comb begin
    we    = 1'b0;
    waddr = {cur_prow, col};
    wdata = rq_data.code;
    if (state == S_CLEAR) begin
      we    = 1'b1;
      waddr = {clr_row, clr_col};
      wdata = tcw_pkg::SPACE_CELL;
    end else if (pop && rq_data.op == tcw_pkg::OP_PUT) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      grid[waddr] <= wdata;
    end
    mem_q <= grid[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      col       <= '0;
      line      <= '0;
      top       <= '0;
      cur_prow  <= '0;
      clr_col   <= '0;
      clr_row   <= '0;
      clr_all   <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (clr_done) begin
            state <= S_IDLE;
          end else if (clr_col == CW'(COLUMNS - 1)) begin
            clr_col <= '0;
            clr_row <= clr_row + 1'b1;
          end else begin
            clr_col <= clr_col + 1'b1;
          end
        end
        S_IDLE: begin
          if (pop) begin
            if (rq_data.op == tcw_pkg::OP_READ) begin
              rd_idx <= rq_data.index;
              state  <= S_RD_MUL;
            end else begin
              col       <= col_next;
              line      <= line_next;
              o_col     <= OCW'(col_next);
              o_row     <= ORW'(line_next);
              o_scr     <= scroll;
              o_char    <= '0;
              if (line_step) begin
                cur_prow <= row_inc(cur_prow);
              end
              // the old top row becomes the new bottom line
              if (scroll) begin
                top     <= row_inc(top);
                clr_row <= top;
                clr_col <= '0;
                clr_all <= 1'b0;
                state   <= S_CLEAR;
              end
            end
          end
        end
        S_RD_MUL: begin
          prod  <= PROD_W'(rd_idx) * PROD_W'(RECIP);
          state <= S_RD_ADR;
        end
        S_RD_ADR: begin
          raddr <= {prow, rem[CW-1:0]};
          rd_ok <= in_range;
          state <= S_RD_MEM;
        end
        S_RD_MEM: begin
          state <= S_RD_OUT;
        end
        S_RD_OUT: begin
          if (slot_free) begin
            o_col     <= OCW'(col);
            o_row     <= ORW'(line);
            o_scr     <= 1'b0;
            o_char    <= rd_ok ? mem_q : '0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hdl/text_console_writer_core.sv -----
// put, control and ignored bytes: the request passes the front stage register and the queue,
// the result is registered as the back end takes it, one per cycle while the result is taken
// and the back end is idle; read: the back end is busy (multiply, address, memory read, output)
// a scroll holds the back end in the clear state while the new bottom line is cleared
// reset: after rst the grid is cleared to spaces, no request accepted until that is done
`default_nettype none
module text_console_writer_core #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  tcw_req_if.sink   request,
  tcw_rsp_if.source result
);

  tcw_pkg::req_t fq_data;
  logic          fq_valid;
  logic          fq_ready;
  tcw_pkg::req_t rq_data;
  logic          rq_valid;
  logic          rq_ready;
  logic          init_done;

  tcw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .request   (request),
    .init_done (init_done),
    .fq_data   (fq_data),
    .fq_valid  (fq_valid),
    .fq_ready  (fq_ready)
  );

  tcw_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_data  (fq_data),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .pop_data   (rq_data),
    .pop_valid  (rq_valid),
    .pop_ready  (rq_ready)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .rq_data   (rq_data),
    .rq_valid  (rq_valid),
    .rq_ready  (rq_ready),
    .init_done (init_done),
    .result    (result)
  );

endmodule
`default_nettype wire

// ----- hdl/tcw_checker.sv -----
`default_nettype none
module tcw_checker #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          out_valid,
  input wire logic [tcw_pkg::COL_OUT_W-1:0] cursor_column,
  input wire logic [tcw_pkg::ROW_OUT_W-1:0] cursor_row,
  input wire logic                          scrolled,
  input wire logic [tcw_pkg::CELL_W-1:0]    read_char
);

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> int'(cursor_column) < COLUMNS)
    else $error("cursor column beyond last column");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> int'(cursor_row) < ROWS)
    else $error("cursor row beyond last row");

  // a scroll always leaves the cursor on the bottom line
  a_scroll_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && scrolled |-> int'(cursor_row) == ((ROWS - 1) % 32))
    else $error("scroll without cursor on last row");

  // grid only ever holds spaces and printable bytes
  a_read_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_char != '0 |->
      !scrolled && read_char >= 7'h20 && read_char <= 7'h7E)
    else $error("read returned a non-printable cell");

endmodule

bind text_console_writer_core tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (result.valid),
  .cursor_column (result.cursor_column),
  .cursor_row    (result.cursor_row),
  .scrolled      (result.scrolled),
  .read_char     (result.read_char)
);
`default_nettype wire
